@@ sv/lek_pkg.sv @@
// Package for the line editor keystroke unit: key codes, microcode fields,
// the control ROM and the key classifier. No dependencies.

package lek_pkg;

	// X11 keysyms and character codes the unit reacts to
	localparam logic [15:0] KEY_LEFT      = 16'hFF51;
	localparam logic [15:0] KEY_RIGHT     = 16'hFF53;
	localparam logic [15:0] KEY_HOME      = 16'hFF50;
	localparam logic [15:0] KEY_END       = 16'hFF57;
	localparam logic [15:0] KEY_BACKSPACE = 16'hFF08;
	localparam logic [15:0] KEY_DELETE    = 16'hFFFF;
	localparam logic [15:0] KEY_SPACE     = 16'h0020;
	localparam logic [15:0] KEY_KP_MUL    = 16'hFFAA;
	localparam logic [15:0] KEY_KP_0      = 16'hFFB0;
	localparam logic [15:0] KEY_KP_9      = 16'hFFB9;
	localparam logic [15:0] KEY_CH_A      = 16'h0061;
	localparam logic [15:0] KEY_CH_B      = 16'h0062;
	localparam logic [15:0] KEY_CH_D      = 16'h0064;
	localparam logic [15:0] KEY_CH_E      = 16'h0065;
	localparam logic [15:0] KEY_CH_F      = 16'h0066;
	localparam logic [15:0] KEY_CH_K      = 16'h006B;
	localparam logic [15:0] KEY_CH_Y      = 16'h0079;

	localparam logic [15:0] ASCII_ZERO    = 16'h0030;
	localparam logic [15:0] CODE_MIN      = 16'd31;
	localparam logic [15:0] CODE_MAX      = 16'd255;
	localparam logic [15:0] CODE_CTRL_SPC = 16'd31;

	localparam logic [5:0]  MAX_LENGTH_RST = 6'd63;

	// Key event classes, resolved when the transaction is taken
	typedef enum logic [3:0] {
		KC_NONE,
		KC_LEFT,
		KC_RIGHT,
		KC_HOME,
		KC_END,
		KC_BKSP,
		KC_DEL_AT,
		KC_INSERT,
		KC_KILL,
		KC_YANK
	} key_class_t;

	// Microcode address
	typedef logic [4:0] upc_t;

	localparam upc_t UA_DISP     = 5'd0;
	localparam upc_t UA_MV_LEFT  = 5'd1;
	localparam upc_t UA_MV_RIGHT = 5'd2;
	localparam upc_t UA_MV_HOME  = 5'd3;
	localparam upc_t UA_MV_END   = 5'd4;
	localparam upc_t UA_RD0      = 5'd5;
	localparam upc_t UA_RD1      = 5'd6;
	localparam upc_t UA_BS0      = 5'd7;
	localparam upc_t UA_RM0      = 5'd8;
	localparam upc_t UA_RM1      = 5'd9;
	localparam upc_t UA_RM2      = 5'd10;
	localparam upc_t UA_IN0      = 5'd11;
	localparam upc_t UA_IN1      = 5'd12;
	localparam upc_t UA_IN2      = 5'd13;
	localparam upc_t UA_KL0      = 5'd14;
	localparam upc_t UA_KL1      = 5'd15;
	localparam upc_t UA_YK0      = 5'd16;
	localparam upc_t UA_YK1      = 5'd17;
	localparam upc_t UA_SC0      = 5'd18;
	localparam upc_t UA_SC1      = 5'd19;
	localparam upc_t UA_FIN      = 5'd20;

	// Buffer read address source
	typedef enum logic [3:0] {
		RD_NONE,
		RD_RIDX,
		RD_CARET,
		RD_CARET_P1,
		RD_LEN_M1,
		RD_PTR,
		RD_PTR_P1,
		RD_PTR_P2,
		RD_PTR_M2
	} rd_sel_t;

	// Buffer write address and data source
	typedef enum logic [2:0] {
		WR_NONE,
		WR_PTR_RDATA,
		WR_LEN_P1_ZERO,
		WR_CARET_CODE,
		WR_CARET_ZERO,
		WR_KCARET_KBYTE,
		WR_KLEN_ZERO
	} wr_sel_t;

	// Loop pointer update
	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_LOAD_CARET,
		PTR_LOAD_LEN,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	// Register update for caret, length, kill record and read byte
	typedef enum logic [3:0] {
		RO_NONE,
		RO_CLAMP,
		RO_CARET_DEC,
		RO_CARET_INC,
		RO_CARET_ZERO,
		RO_CARET_LEN,
		RO_BYTE_CAP,
		RO_LEN_DEC,
		RO_INS_DONE,
		RO_KILL_SAVE,
		RO_KILL_CLR,
		RO_LEN_PTR
	} reg_op_t;

	// Sequencing: fall through, jump, dispatch on the key class, jump on a datapath condition, or hold when done
	typedef enum logic [3:0] {
		CD_NEXT,
		CD_ALWAYS,
		CD_DECODE,
		CD_CARET_ZERO,
		CD_PTR_LT_LEN,
		CD_PTR_GE_LEN,
		CD_PTR_EQ_CARET,
		CD_PTR_NE_CARET,
		CD_SCAN_GO,
		CD_DONE
	} cond_t;

	typedef struct packed {
		rd_sel_t rd;
		wr_sel_t wr;
		ptr_op_t ptr;
		reg_op_t rop;
		cond_t   cond;
		upc_t    target;
	} uword_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic caret_zero;
		logic ptr_lt_len;
		logic ptr_eq_caret;
		logic scan_go;
		logic ins_ok;
		logic yank_ok;
	} dp_stat_t;

	// Control ROM
	function automatic uword_t lek_ucode(input upc_t a);
		uword_t w;
		w = '{rd: RD_NONE, wr: WR_NONE, ptr: PTR_HOLD, rop: RO_NONE,
			cond: CD_NEXT, target: UA_FIN};
		case (a)
			UA_DISP: begin
				w.rop = RO_CLAMP;
				w.cond = CD_DECODE;
			end
			UA_MV_LEFT: begin
				w.rop = RO_CARET_DEC;
				w.cond = CD_ALWAYS;
			end
			UA_MV_RIGHT: begin
				w.rop = RO_CARET_INC;
				w.cond = CD_ALWAYS;
			end
			UA_MV_HOME: begin
				w.rop = RO_CARET_ZERO;
				w.cond = CD_ALWAYS;
			end
			UA_MV_END: begin
				w.rop = RO_CARET_LEN;
				w.cond = CD_ALWAYS;
			end
			UA_RD0: begin
				w.rd = RD_RIDX;
			end
			UA_RD1: begin
				w.rop = RO_BYTE_CAP;
				w.cond = CD_ALWAYS;
			end
			UA_BS0: begin
				w.rop = RO_CARET_DEC;
				w.cond = CD_CARET_ZERO;
			end
			UA_RM0: begin
				w.ptr = PTR_LOAD_CARET;
				w.rd = RD_CARET_P1;
				w.cond = CD_PTR_GE_LEN;
			end
			UA_RM1: begin
				w.wr = WR_PTR_RDATA;
				w.rd = RD_PTR_P2;
				w.ptr = PTR_INC;
				w.cond = CD_PTR_LT_LEN;
				w.target = UA_RM1;
			end
			UA_RM2: begin
				w.rop = RO_LEN_DEC;
				w.cond = CD_ALWAYS;
			end
			UA_IN0: begin
				w.wr = WR_LEN_P1_ZERO;
				w.ptr = PTR_LOAD_LEN;
				w.rd = RD_LEN_M1;
				w.cond = CD_PTR_EQ_CARET;
				w.target = UA_IN2;
			end
			UA_IN1: begin
				w.wr = WR_PTR_RDATA;
				w.rd = RD_PTR_M2;
				w.ptr = PTR_DEC;
				w.cond = CD_PTR_NE_CARET;
				w.target = UA_IN1;
			end
			UA_IN2: begin
				w.wr = WR_CARET_CODE;
				w.rop = RO_INS_DONE;
				w.cond = CD_ALWAYS;
			end
			UA_KL0: begin
				w.rd = RD_CARET;
			end
			UA_KL1: begin
				w.wr = WR_CARET_ZERO;
				w.rop = RO_KILL_SAVE;
				w.cond = CD_ALWAYS;
			end
			UA_YK0: begin
				w.wr = WR_KCARET_KBYTE;
				w.rop = RO_KILL_CLR;
			end
			UA_YK1: begin
				w.wr = WR_KLEN_ZERO;
				w.ptr = PTR_ZERO;
			end
			UA_SC0: begin
				w.rd = RD_PTR;
			end
			UA_SC1: begin
				w.rd = RD_PTR_P1;
				w.ptr = PTR_INC;
				w.rop = RO_LEN_PTR;
				w.cond = CD_SCAN_GO;
				w.target = UA_SC1;
			end
			UA_FIN: begin
				w.cond = CD_DONE;
			end
			default: begin
				w.cond = CD_ALWAYS;
			end
		endcase
		return w;
	endfunction

	// Character a key would insert: keypad symbols fold onto ASCII
	function automatic logic [15:0] lek_raw_code(input logic [15:0] key, input logic ctrl);
		logic [15:0] code;
		if (ctrl) begin
			code = CODE_CTRL_SPC;
		end else if (key >= KEY_KP_MUL && key <= KEY_KP_9) begin
			code = key - KEY_KP_0 + ASCII_ZERO;
		end else begin
			code = key;
		end
		return code;
	endfunction

	// Sort a key event into the action it takes
	function automatic key_class_t lek_classify(input logic [15:0] key, input logic ctrl);
		logic [15:0] code;
		key_class_t  c;
		code = lek_raw_code(key, ctrl);
		c = KC_NONE;
		if (key == KEY_LEFT) begin
			c = KC_LEFT;
		end else if (key == KEY_RIGHT) begin
			c = KC_RIGHT;
		end else if (key == KEY_HOME) begin
			c = KC_HOME;
		end else if (key == KEY_END) begin
			c = KC_END;
		end else if (key == KEY_BACKSPACE || key == KEY_DELETE) begin
			c = KC_BKSP;
		end else if (ctrl) begin
			if (key == KEY_SPACE) begin
				c = KC_INSERT;
			end else if (key == KEY_CH_A) begin
				c = KC_HOME;
			end else if (key == KEY_CH_B) begin
				c = KC_LEFT;
			end else if (key == KEY_CH_E) begin
				c = KC_END;
			end else if (key == KEY_CH_F) begin
				c = KC_RIGHT;
			end else if (key == KEY_CH_D) begin
				c = KC_DEL_AT;
			end else if (key == KEY_CH_K) begin
				c = KC_KILL;
			end else if (key == KEY_CH_Y) begin
				c = KC_YANK;
			end
		end else if (code >= CODE_MIN && code <= CODE_MAX) begin
			c = KC_INSERT;
		end
		return c;
	endfunction

endpackage

@@ sv/lek_seq.sv @@
// Microcode sequencer of the line editor keystroke unit: step counter,
// control ROM lookup, key dispatch and conditional jumps. Uses lek_pkg.

module lek_seq
	import lek_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        action,
	input  logic [15:0] key_code,
	input  logic        ctrl_held,
	input  dp_stat_t    stat,
	input  logic        out_free,
	output uword_t      ctrl,
	output logic        busy,
	output logic        done
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} seq_state_t;

	seq_state_t state_q;
	upc_t       upc_q;
	upc_t       upc_d;
	upc_t       upc_inc;
	upc_t       disp_target;
	logic       action_q;
	key_class_t cls_q;
	uword_t     uw;

	assign uw = lek_ucode(upc_q);
	assign upc_inc = upc_q + 5'd1;

	// Pick the program entry for the pending transaction
	always_comb begin
		if (action_q) begin
			disp_target = UA_RD0;
		end else begin
			case (cls_q)
				KC_LEFT:   disp_target = UA_MV_LEFT;
				KC_RIGHT:  disp_target = UA_MV_RIGHT;
				KC_HOME:   disp_target = UA_MV_HOME;
				KC_END:    disp_target = UA_MV_END;
				KC_BKSP:   disp_target = UA_BS0;
				KC_DEL_AT: disp_target = UA_RM0;
				KC_INSERT: disp_target = stat.ins_ok ? UA_IN0 : UA_FIN;
				KC_KILL:   disp_target = UA_KL0;
				KC_YANK:   disp_target = stat.yank_ok ? UA_YK0 : UA_FIN;
				default:   disp_target = UA_FIN;
			endcase
		end
	end

	// Next step address
	always_comb begin
		case (uw.cond)
			CD_NEXT:         upc_d = upc_inc;
			CD_ALWAYS:       upc_d = uw.target;
			CD_DECODE:       upc_d = disp_target;
			CD_CARET_ZERO:   upc_d = stat.caret_zero ? uw.target : upc_inc;
			CD_PTR_LT_LEN:   upc_d = stat.ptr_lt_len ? uw.target : upc_inc;
			CD_PTR_GE_LEN:   upc_d = !stat.ptr_lt_len ? uw.target : upc_inc;
			CD_PTR_EQ_CARET: upc_d = stat.ptr_eq_caret ? uw.target : upc_inc;
			CD_PTR_NE_CARET: upc_d = !stat.ptr_eq_caret ? uw.target : upc_inc;
			CD_SCAN_GO:      upc_d = stat.scan_go ? uw.target : upc_inc;
			CD_DONE:         upc_d = upc_q;
			default:         upc_d = UA_FIN;
		endcase
	end

	assign busy = (state_q == S_RUN);
	assign done = busy && (uw.cond == CD_DONE) && out_free;
	assign ctrl = busy ? uw : lek_ucode(UA_FIN);

	// Hold state, step counter and the latched key class
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			upc_q <= UA_FIN;
			action_q <= 1'b0;
			cls_q <= KC_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
						upc_q <= UA_DISP;
						action_q <= action;
						cls_q <= lek_classify(key_code, ctrl_held);
					end
				end
				S_RUN: begin
					upc_q <= upc_d;
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/lek_dp.sv @@
// Datapath of the line editor keystroke unit: text buffer memory with
// per-entry valid bits, caret, length, kill record and loop pointer. Uses lek_pkg.

module lek_dp
	import lek_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [15:0]                     key_code,
	input  logic                            ctrl_held,
	input  logic [5:0]                      read_index,
	input  logic                            cfg_wr_en,
	input  logic [5:0]                      cfg_wr_data,
	input  uword_t                          ctrl,
	output dp_stat_t                        stat,
	output logic [$clog2(BUFFER_DEPTH)-1:0] caret,
	output logic [$clog2(BUFFER_DEPTH)-1:0] length,
	output logic [7:0]                      rbyte
);

	localparam int IW = $clog2(BUFFER_DEPTH);
	localparam int CW = (IW > 6) ? IW : 6;
	localparam logic [IW-1:0] LAST = IW'(BUFFER_DEPTH - 1);

	logic [7:0]              mem [BUFFER_DEPTH];
	logic [BUFFER_DEPTH-1:0] valid_q;
	logic [7:0]              mem_q;
	logic                    rvalid_q;
	logic [7:0]              rdata;

	logic [IW-1:0] caret_q;
	logic [IW-1:0] len_q;
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] ptr_d;
	logic [IW-1:0] caret_eff;
	logic          kill_valid_q;
	logic [IW-1:0] kill_caret_q;
	logic [IW-1:0] kill_len_q;
	logic [7:0]    kill_byte_q;
	logic [5:0]    max_q;
	logic [7:0]    byte_q;
	logic [7:0]    code_q;
	logic [5:0]    ridx_q;
	logic          ridx_ok_q;
	logic [15:0]   raw_code;

	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_go;
	logic          wr_go;

	assign rdata = rvalid_q ? mem_q : 8'd0;
	assign caret_eff = (caret_q > len_q) ? len_q : caret_q;
	assign raw_code = lek_raw_code(key_code, ctrl_held);

	// Loop pointer next value
	always_comb begin
		case (ctrl.ptr)
			PTR_HOLD:       ptr_d = ptr_q;
			PTR_ZERO:       ptr_d = '0;
			PTR_LOAD_CARET: ptr_d = caret_q;
			PTR_LOAD_LEN:   ptr_d = len_q;
			PTR_INC:        ptr_d = ptr_q + IW'(1);
			PTR_DEC:        ptr_d = ptr_q - IW'(1);
			default:        ptr_d = ptr_q;
		endcase
	end

	// Read address select
	always_comb begin
		rd_en = 1'b1;
		case (ctrl.rd)
			RD_RIDX:     rd_addr = IW'(ridx_q);
			RD_CARET:    rd_addr = caret_q;
			RD_CARET_P1: rd_addr = caret_q + IW'(1);
			RD_LEN_M1:   rd_addr = len_q - IW'(1);
			RD_PTR:      rd_addr = ptr_q;
			RD_PTR_P1:   rd_addr = ptr_q + IW'(1);
			RD_PTR_P2:   rd_addr = ptr_q + IW'(2);
			RD_PTR_M2:   rd_addr = ptr_q - IW'(2);
			default: begin
				rd_en = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	// Write address and data select
	always_comb begin
		wr_en = 1'b1;
		case (ctrl.wr)
			WR_PTR_RDATA: begin
				wr_addr = ptr_q;
				wr_data = rdata;
			end
			WR_LEN_P1_ZERO: begin
				wr_addr = len_q + IW'(1);
				wr_data = 8'd0;
			end
			WR_CARET_CODE: begin
				wr_addr = caret_q;
				wr_data = code_q;
			end
			WR_CARET_ZERO: begin
				wr_addr = caret_q;
				wr_data = 8'd0;
			end
			WR_KCARET_KBYTE: begin
				wr_addr = kill_caret_q;
				wr_data = kill_byte_q;
			end
			WR_KLEN_ZERO: begin
				wr_addr = kill_len_q;
				wr_data = 8'd0;
			end
			default: begin
				wr_en = 1'b0;
				wr_addr = '0;
				wr_data = 8'd0;
			end
		endcase
	end

	// The last entry stays zero as the terminator; drop reads past the end
	assign rd_go = rd_en && (rd_addr <= LAST);
	assign wr_go = wr_en && (wr_addr < LAST);

	// Text buffer storage
	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_go) begin
			mem_q <= mem[rd_addr];
		end
	end

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_go) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_go) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	// Latch the transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= raw_code[7:0];
			ridx_q <= read_index;
			ridx_ok_q <= (32'(read_index) < 32'(BUFFER_DEPTH));
		end
	end

	// Editor state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caret_q <= '0;
			len_q <= '0;
			ptr_q <= '0;
			kill_valid_q <= 1'b0;
			kill_caret_q <= '0;
			kill_len_q <= '0;
			kill_byte_q <= 8'd0;
			max_q <= MAX_LENGTH_RST;
			byte_q <= 8'd0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if (accept) begin
				byte_q <= 8'd0;
			end
			ptr_q <= ptr_d;
			case (ctrl.rop)
				RO_CLAMP: caret_q <= caret_eff;
				RO_CARET_DEC: begin
					if (caret_q != '0) begin
						caret_q <= caret_q - IW'(1);
					end
				end
				RO_CARET_INC: begin
					if (caret_q < len_q) begin
						caret_q <= caret_q + IW'(1);
					end
				end
				RO_CARET_ZERO: caret_q <= '0;
				RO_CARET_LEN:  caret_q <= len_q;
				RO_BYTE_CAP:   byte_q <= ridx_ok_q ? rdata : 8'd0;
				RO_LEN_DEC:    len_q <= len_q - IW'(1);
				RO_INS_DONE: begin
					caret_q <= caret_q + IW'(1);
					len_q <= len_q + IW'(1);
				end
				RO_KILL_SAVE: begin
					kill_caret_q <= caret_q;
					kill_len_q <= len_q;
					kill_byte_q <= rdata;
					kill_valid_q <= 1'b1;
					len_q <= caret_q;
				end
				RO_KILL_CLR: kill_valid_q <= 1'b0;
				RO_LEN_PTR:  len_q <= ptr_q;
				default: begin
				end
			endcase
		end
	end

	// Flags for the sequencer
	assign stat.caret_zero = (caret_q == '0);
	assign stat.ptr_lt_len = (ptr_d < len_q);
	assign stat.ptr_eq_caret = (ptr_d == caret_q);
	assign stat.scan_go = (rdata != 8'd0) && (ptr_q != LAST);
	assign stat.ins_ok = (CW'(len_q) < CW'(max_q)) && (len_q != LAST);
	assign stat.yank_ok = kill_valid_q && (caret_eff == kill_caret_q);

	assign caret = caret_q;
	assign length = len_q;
	assign rbyte = byte_q;

endmodule

@@ sv/line_editor_keystroke_unit.sv @@
// Top level of the line editor keystroke unit: handshakes, result register,
// and the sequencer and datapath. Uses lek_pkg, lek_seq and lek_dp.

// Single-line text entry with emacs-style keys. Each transaction is either a
// key event (X11 keysym plus control flag) or a read of one buffer byte; it
// returns the caret, the text length and the byte read. Items are handled one
// at a time by a microcoded sequencer over a text buffer with one read and
// one write per cycle. An insert shifts the bytes from the caret onward up
// by one place, Ctrl-d and Backspace shift them down, and a yank rescans
// the length. The next item is taken only after the previous result lands
// in the output register; while a result waits for the receiver the
// sequencer holds on its last step. The buffer reads as all zero after
// reset through per-entry valid bits; there is no clearing pass.

module line_editor_keystroke_unit
	import lek_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        action,
	input  logic [15:0] key_code,
	input  logic        ctrl_held,
	input  logic [5:0]  read_index,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [5:0]  caret_pos,
	output logic [5:0]  text_length,
	output logic [7:0]  read_byte,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data
);

	localparam int IW = $clog2(BUFFER_DEPTH);

	logic          accept;
	logic          busy;
	logic          done;
	logic          out_free;
	uword_t        ctrl;
	dp_stat_t      stat;
	logic [IW-1:0] caret;
	logic [IW-1:0] length;
	logic [7:0]    rbyte;

	logic          result_valid_q;
	logic [5:0]    caret_pos_q;
	logic [5:0]    text_length_q;
	logic [7:0]    read_byte_q;

	assign item_ready = !busy;
	assign accept = item_valid && item_ready;
	assign out_free = !result_valid_q || result_ready;

	lek_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.action   (action),
		.key_code (key_code),
		.ctrl_held(ctrl_held),
		.stat     (stat),
		.out_free (out_free),
		.ctrl     (ctrl),
		.busy     (busy),
		.done     (done)
	);

	lek_dp #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.key_code   (key_code),
		.ctrl_held  (ctrl_held),
		.read_index (read_index),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.ctrl       (ctrl),
		.stat       (stat),
		.caret      (caret),
		.length     (length),
		.rbyte      (rbyte)
	);

	// Hold the finished result until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (done) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Capture the result fields
	always_ff @(posedge clk) begin
		if (done) begin
			caret_pos_q <= 6'(caret);
			text_length_q <= 6'(length);
			read_byte_q <= rbyte;
		end
	end

	assign result_valid = result_valid_q;
	assign caret_pos = caret_pos_q;
	assign text_length = text_length_q;
	assign read_byte = read_byte_q;

endmodule
